// File: rtl/ecn_ce_marker_byte_stream_unit_macros.svh
// Assertion macros for the ECN CE marker RTL.
// Each macro expects clk and arst_n to be visible in the module that uses it.
`ifndef ECN_CE_MARKER_BYTE_STREAM_UNIT_MACROS_SVH
`define ECN_CE_MARKER_BYTE_STREAM_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ECNCE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define ECNCE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ecnce_pkg.sv
// Types and constants for the ECN CE marker on an Ethernet byte stream.
// No dependencies; imported by every module of the block.
package ecnce_pkg;

	typedef struct packed {
		logic [7:0]  in_byte;
		logic        first_byte;
		logic        last_byte;
		logic [15:0] queue_length;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       byte_changed;
		logic       frame_congested;
		logic [2:0] frame_kind;
	} result_t;

	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic REG_MARK_ENABLE     = 1'b0;
	localparam logic REG_QUEUE_THRESHOLD = 1'b1;

	// Frame kind codes
	localparam logic [2:0] KIND_OTHER      = 3'd0;
	localparam logic [2:0] KIND_IPV4       = 3'd1;
	localparam logic [2:0] KIND_IPV6       = 3'd2;
	localparam logic [2:0] KIND_PPPOE_IPV4 = 3'd3;
	localparam logic [2:0] KIND_PPPOE_IPV6 = 3'd4;

	localparam logic [7:0]  TYPE_OFFSET    = 8'd12;
	localparam logic [15:0] TYPE_PPPOE     = 16'h8864;
	localparam logic [15:0] TYPE_IPV4      = 16'h0800;
	localparam logic [15:0] TYPE_IPV6      = 16'h86DD;
	localparam logic [15:0] PPP_IPV4       = 16'h0021;
	localparam logic [15:0] PPP_IPV6       = 16'h0057;
	localparam logic [7:0]  CE_MASK_IPV4   = 8'h03;
	localparam logic [7:0]  CE_MASK_IPV6   = 8'h30;
	localparam logic [7:0]  OFFSET_MAX     = 8'hFF;

	// 0x8100 and 0x9100 differ only in bit 4 of the high byte.
	function automatic logic is_tag(input logic [7:0] hi, input logic [7:0] lo);
		logic vlan;
		logic other;
		vlan  = ((hi & 8'hEF) == 8'h81) && (lo == 8'h00);
		other = (hi == 8'h88) && ((lo == 8'hA8) || (lo == 8'h4C));
		return vlan || other;
	endfunction

endpackage

// File: rtl/ecn_ce_marker_byte_stream_unit.sv
// ECN CE marker on an Ethernet byte stream: an accepted transaction goes from the input
// register through the parse logic to the result register, all advancing together; one
// byte per cycle sustained while the sink takes results.
// Reset clears marking (disabled), sets the queue threshold to 65535 and returns
// the frame parser to the start of a frame; both stages come out of reset empty.
// Depends on ecnce_pkg, ecnce_in_stage, ecnce_parser and ecnce_out_stage.
module ecn_ce_marker_byte_stream_unit #(
	parameter int MAX_TAGS = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  ecnce_pkg::item_t                 item,
	output logic                             result_valid,
	input  logic                             result_ready,
	output ecnce_pkg::result_t               result,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [ecnce_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ecnce_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    out_free;
	logic    advance;
	result_t result_s1;

	assign advance = valid_s1 && out_free;

	ecnce_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	ecnce_parser #(
		.MAX_TAGS (MAX_TAGS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (advance),
		.item_s1   (item_s1),
		.result    (result_s1)
	);

	ecnce_out_stage u_out_stage (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (valid_s1),
		.load_ready   (out_free),
		.load_data    (result_s1),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// File: rtl/ecnce_in_stage.sv
// Input register of the ECN CE marker: holds one accepted transaction.
// Depends on ecnce_pkg.
module ecnce_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  ecnce_pkg::item_t item,
	input  logic             advance,
	output logic             valid_s1,
	output ecnce_pkg::item_t item_s1
);
	import ecnce_pkg::*;

	// The register frees up in the same cycle that its content moves on.
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

endmodule

// File: rtl/ecnce_parser.sv
// Header walker and CE marking logic with the frame state and configuration registers.
// Depends on ecnce_pkg and the assertion macro header.
`include "ecn_ce_marker_byte_stream_unit_macros.svh"

module ecnce_parser #(
	parameter int MAX_TAGS = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [ecnce_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                advance,
	input  ecnce_pkg::item_t                    item_s1,
	output ecnce_pkg::result_t                  result
);
	import ecnce_pkg::*;

	localparam int TAG_W = $clog2(MAX_TAGS + 1);
	localparam logic [TAG_W-1:0] TAG_LIMIT = TAG_W'(MAX_TAGS);

	localparam logic [2:0] PH_TYPE_HI = 3'd0;
	localparam logic [2:0] PH_TYPE_LO = 3'd1;
	localparam logic [2:0] PH_PPP_HI  = 3'd2;
	localparam logic [2:0] PH_PPP_LO  = 3'd3;
	localparam logic [2:0] PH_MARK    = 3'd4;
	localparam logic [2:0] PH_DONE    = 3'd5;

	logic             mark_enable_q;
	logic [15:0]      queue_threshold_q;

	logic [7:0]       offset_q;
	logic [2:0]       phase_q;
	logic [7:0]       field_hi_q;
	logic [7:0]       base_q;
	logic [TAG_W-1:0] tags_q;
	logic             congested_q;
	logic [2:0]       kind_q;

	logic [7:0]       cur_offset;
	logic [2:0]       cur_phase;
	logic [7:0]       cur_hi;
	logic [7:0]       cur_base;
	logic [TAG_W-1:0] cur_tags;
	logic             cur_congested;
	logic [2:0]       cur_kind;

	logic [7:0]       nxt_offset;
	logic [2:0]       nxt_phase;
	logic [7:0]       nxt_hi;
	logic [7:0]       nxt_base;
	logic [TAG_W-1:0] nxt_tags;
	logic [2:0]       nxt_kind;

	logic [7:0]       b;
	logic [15:0]      field;
	logic [7:0]       out_b;
	logic             changed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_enable_q     <= 1'b0;
			queue_threshold_q <= 16'hFFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MARK_ENABLE:     mark_enable_q <= cfg_data[0];
				REG_QUEUE_THRESHOLD: queue_threshold_q <= cfg_data[15:0];
				default:             ;
			endcase
		end
	end

	// A first byte restarts the frame, so the stored state is bypassed with reset values.
	always_comb begin
		b = item_s1.in_byte;
		if (item_s1.first_byte) begin
			cur_offset    = '0;
			cur_phase     = PH_TYPE_HI;
			cur_hi        = '0;
			cur_base      = TYPE_OFFSET;
			cur_tags      = '0;
			cur_congested = mark_enable_q && (item_s1.queue_length > queue_threshold_q);
			cur_kind      = KIND_OTHER;
		end else begin
			cur_offset    = offset_q;
			cur_phase     = phase_q;
			cur_hi        = field_hi_q;
			cur_base      = base_q;
			cur_tags      = tags_q;
			cur_congested = congested_q;
			cur_kind      = kind_q;
		end
		field = {cur_hi, b};

		nxt_offset = (cur_offset != OFFSET_MAX) ? cur_offset + 8'd1 : cur_offset;
		nxt_phase  = cur_phase;
		nxt_hi     = cur_hi;
		nxt_base   = cur_base;
		nxt_tags   = cur_tags;
		nxt_kind   = cur_kind;
		out_b      = b;
		changed    = 1'b0;

		case (cur_phase)
			PH_TYPE_HI: begin
				if (cur_offset == cur_base) begin
					nxt_hi    = b;
					nxt_phase = PH_TYPE_LO;
				end
			end
			PH_TYPE_LO: begin
				if (is_tag(cur_hi, b)) begin
					if (cur_tags < TAG_LIMIT) begin
						nxt_tags  = cur_tags + TAG_W'(1);
						nxt_base  = cur_base + 8'd4;
						nxt_phase = PH_TYPE_HI;
					end else begin
						nxt_phase = PH_DONE;
					end
				end else if (field == TYPE_PPPOE) begin
					nxt_phase = PH_PPP_HI;
				end else if (field == TYPE_IPV4 || field == TYPE_IPV6) begin
					nxt_kind  = (field == TYPE_IPV4) ? KIND_IPV4 : KIND_IPV6;
					nxt_base  = cur_base + 8'd3;
					nxt_phase = PH_MARK;
				end else begin
					nxt_phase = PH_DONE;
				end
			end
			PH_PPP_HI: begin
				if (cur_offset == cur_base + 8'd8) begin
					nxt_hi    = b;
					nxt_phase = PH_PPP_LO;
				end
			end
			PH_PPP_LO: begin
				if (field == PPP_IPV4 || field == PPP_IPV6) begin
					nxt_kind  = (field == PPP_IPV4) ? KIND_PPPOE_IPV4 : KIND_PPPOE_IPV6;
					nxt_base  = cur_base + 8'd11;
					nxt_phase = PH_MARK;
				end else begin
					nxt_phase = PH_DONE;
				end
			end
			PH_MARK: begin
				if (cur_offset == cur_base) begin
					if (cur_congested) begin
						// Odd kinds carry IPv4: ECN sits in the TOS byte, else in the traffic class.
						out_b   = b | (cur_kind[0] ? CE_MASK_IPV4 : CE_MASK_IPV6);
						changed = 1'b1;
					end
					nxt_phase = PH_DONE;
				end
			end
			default: ;
		endcase

		result.out_byte        = out_b;
		result.out_last        = item_s1.last_byte;
		result.byte_changed    = changed;
		result.frame_congested = cur_congested;
		result.frame_kind      = nxt_kind;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= '0;
			phase_q     <= PH_TYPE_HI;
			field_hi_q  <= '0;
			base_q      <= TYPE_OFFSET;
			tags_q      <= '0;
			congested_q <= 1'b0;
			kind_q      <= KIND_OTHER;
		end else if (advance) begin
			if (item_s1.last_byte) begin
				offset_q    <= '0;
				phase_q     <= PH_TYPE_HI;
				field_hi_q  <= '0;
				base_q      <= TYPE_OFFSET;
				tags_q      <= '0;
				congested_q <= 1'b0;
				kind_q      <= KIND_OTHER;
			end else begin
				offset_q    <= nxt_offset;
				phase_q     <= nxt_phase;
				field_hi_q  <= nxt_hi;
				base_q      <= nxt_base;
				tags_q      <= nxt_tags;
				congested_q <= cur_congested;
				kind_q      <= nxt_kind;
			end
		end
	end

	`ECNCE_ASSERT_IMP(a_mark_needs_congestion, advance && result.byte_changed, result.frame_congested, "byte marked in a frame that is not congested")
	`ECNCE_ASSERT_IMP(a_mark_needs_kind, advance && result.byte_changed, result.frame_kind != KIND_OTHER, "byte marked in an unclassified frame")
	`ECNCE_ASSERT_NEXT(a_frame_end_clears, advance && item_s1.last_byte, offset_q == '0 && phase_q == PH_TYPE_HI && !congested_q, "frame state not cleared after the last byte")
	`ECNCE_ASSERT_IMP(a_tags_bounded, 1'b1, tags_q <= TAG_LIMIT, "tag count beyond its limit")

endmodule

// File: rtl/ecnce_out_stage.sv
// Result register of the ECN CE marker: holds one result until the sink takes it.
// Depends on ecnce_pkg.
module ecnce_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load_valid,
	output logic               load_ready,
	input  ecnce_pkg::result_t load_data,
	output logic               result_valid,
	input  logic               result_ready,
	output ecnce_pkg::result_t result
);
	import ecnce_pkg::*;

	assign load_ready = !result_valid || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load_ready) begin
			result_valid <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			result <= load_data;
		end
	end

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the ECN CE marker on an Ethernet byte stream.
// Depends on ecnce_pkg and ecn_ce_marker_byte_stream_unit; predicts each output byte itself.
module testbench;
	import ecnce_pkg::*;

	localparam int MAX_TAGS    = 4;
	localparam int LATENCY     = 2;
	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT    = 36;
	localparam int MAX_REPORTS = 10;

	localparam logic [15:0] TAG_CVLAN  = 16'h8100;
	localparam logic [15:0] TAG_QINQ   = 16'h9100;
	localparam logic [15:0] TAG_SVLAN  = 16'h88A8;
	localparam logic [15:0] TAG_PBB    = 16'h884C;
	localparam logic [7:0]  PPPOE_VT   = 8'h11;
	localparam logic [7:0]  IPV4_VIHL  = 8'h45;
	localparam logic [7:0]  IPV6_VTC   = 8'h60;

	typedef enum logic [2:0] {
		PH_TYPE_HI, PH_TYPE_LO, PH_PPP_HI, PH_PPP_LO, PH_MARK, PH_DONE
	} parse_phase_e;

	typedef enum int {
		SHAPE_IPV4, SHAPE_IPV6, SHAPE_PPPOE_V4, SHAPE_PPPOE_V6, SHAPE_PPPOE_BAD, SHAPE_UNKNOWN
	} shape_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	item_t       item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_MARK_ENABLE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predictor state: configuration and the frame parser.
	logic         mdl_mark_en;
	logic [15:0]  mdl_threshold;
	logic [7:0]   mdl_offset;
	parse_phase_e mdl_phase;
	logic [7:0]   mdl_high;
	logic [7:0]   mdl_base;
	logic [3:0]   mdl_tags;
	logic         mdl_congested;
	logic [2:0]   mdl_kind;

	result_t     marked_bytes_due[$];
	logic [7:0]  frame_buf[$];

	int  errors = 0;
	int  cycle_count = 0;
	int  bytes_sent = 0;
	int  frames_sent = 0;
	int  bytes_marked = 0;
	int  settings_used = 0;
	bit  steady = 1'b0;
	int  hold_req = 0;
	int  hold_left = 0;

	ecn_ce_marker_byte_stream_unit #(.MAX_TAGS(MAX_TAGS)) dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// Receiver: random stalls, a long hold-off on request, or none at all.
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else if (steady) begin
			result_ready <= 1'b1;
		end else begin
			result_ready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	function automatic void clear_frame();
		mdl_offset    = '0;
		mdl_phase     = PH_TYPE_HI;
		mdl_high      = '0;
		mdl_base      = TYPE_OFFSET;
		mdl_tags      = '0;
		mdl_congested = 1'b0;
		mdl_kind      = KIND_OTHER;
	endfunction

	function automatic result_t predict_marked_byte(item_t it);
		result_t    r;
		logic [7:0] ob;
		logic       chg;
		logic [15:0] ftype;
		logic       tag;
		ob = it.in_byte;
		chg = 1'b0;
		if (it.first_byte) begin
			clear_frame();
			mdl_congested = mdl_mark_en && (it.queue_length > mdl_threshold);
		end
		ftype = {mdl_high, it.in_byte};
		tag = (ftype == TAG_CVLAN) || (ftype == TAG_QINQ) ||
			(ftype == TAG_SVLAN) || (ftype == TAG_PBB);
		case (mdl_phase)
			PH_TYPE_HI: begin
				if (mdl_offset == mdl_base) begin
					mdl_high  = it.in_byte;
					mdl_phase = PH_TYPE_LO;
				end
			end
			PH_TYPE_LO: begin
				if (tag) begin
					if (mdl_tags < MAX_TAGS) begin
						mdl_tags++;
						mdl_base  = mdl_base + 8'd4;
						mdl_phase = PH_TYPE_HI;
					end else begin
						mdl_phase = PH_DONE;
					end
				end else if (ftype == TYPE_PPPOE) begin
					mdl_phase = PH_PPP_HI;
				end else if (ftype == TYPE_IPV4 || ftype == TYPE_IPV6) begin
					mdl_kind  = (ftype == TYPE_IPV4) ? KIND_IPV4 : KIND_IPV6;
					mdl_base  = mdl_base + 8'd3;
					mdl_phase = PH_MARK;
				end else begin
					mdl_phase = PH_DONE;
				end
			end
			PH_PPP_HI: begin
				if (mdl_offset == mdl_base + 8'd8) begin
					mdl_high  = it.in_byte;
					mdl_phase = PH_PPP_LO;
				end
			end
			PH_PPP_LO: begin
				if (ftype == PPP_IPV4 || ftype == PPP_IPV6) begin
					mdl_kind  = (ftype == PPP_IPV4) ? KIND_PPPOE_IPV4 : KIND_PPPOE_IPV6;
					mdl_base  = mdl_base + 8'd11;
					mdl_phase = PH_MARK;
				end else begin
					mdl_phase = PH_DONE;
				end
			end
			PH_MARK: begin
				if (mdl_offset == mdl_base) begin
					if (mdl_congested) begin
						// IPv4 kinds carry ECN in the low bits of the TOS byte.
						ob  = ob | (mdl_kind[0] ? CE_MASK_IPV4 : CE_MASK_IPV6);
						chg = 1'b1;
					end
					mdl_phase = PH_DONE;
				end
			end
			default: ;
		endcase
		if (mdl_offset != OFFSET_MAX)
			mdl_offset++;
		r.out_byte        = ob;
		r.out_last        = it.last_byte;
		r.byte_changed    = chg;
		r.frame_congested = mdl_congested;
		r.frame_kind      = mdl_kind;
		if (it.last_byte)
			clear_frame();
		return r;
	endfunction

	// Each output transaction is checked against the oldest prediction.
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && result_valid && result_ready) begin
			if (marked_bytes_due.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected output transaction: %p", result);
			end else begin
				exp_r = marked_bytes_due.pop_front();
				if (result.byte_changed === 1'b1)
					bytes_marked++;
				if (result.out_byte !== exp_r.out_byte ||
					result.out_last !== exp_r.out_last ||
					result.byte_changed !== exp_r.byte_changed ||
					result.frame_congested !== exp_r.frame_congested ||
					result.frame_kind !== exp_r.frame_kind) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("mismatch at cycle %0d: expected %p, got %p",
							cycle_count, exp_r, result);
				end
			end
		end
	end

	// Entered and left just after a falling edge.
	task automatic send_item(input item_t it);
		if (!steady) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				item_valid <= 1'b0;
				@(negedge clk);
			end
		end
		item       <= it;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		marked_bytes_due.push_back(predict_marked_byte(it));
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		do
			@(negedge clk);
		while (marked_bytes_due.size() != 0);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MARK_ENABLE)
			mdl_mark_en = value[0];
		else
			mdl_threshold = value[15:0];
	endtask

	task automatic set_marking(input logic en, input logic [15:0] thr);
		write_reg(REG_MARK_ENABLE, {{(CFG_DATA_W-1){1'b0}}, en});
		write_reg(REG_QUEUE_THRESHOLD, thr);
		settings_used++;
	endtask

	task automatic push_pair(input logic [15:0] v);
		frame_buf.push_back(v[15:8]);
		frame_buf.push_back(v[7:0]);
	endtask

	// Builds a frame in frame_buf; cut of zero keeps the whole frame.
	task automatic build_frame(input shape_e shape, input int ntags, input int tail, input int cut);
		logic [15:0] tag_type;
		frame_buf.delete();
		repeat (12) frame_buf.push_back(8'($urandom));
		repeat (ntags) begin
			case ($urandom_range(3))
				0: tag_type = TAG_CVLAN;
				1: tag_type = TAG_QINQ;
				2: tag_type = TAG_SVLAN;
				default: tag_type = TAG_PBB;
			endcase
			push_pair(tag_type);
			push_pair(16'($urandom));
		end
		case (shape)
			SHAPE_IPV4: push_pair(TYPE_IPV4);
			SHAPE_IPV6: push_pair(TYPE_IPV6);
			SHAPE_UNKNOWN: push_pair(16'($urandom));
			default: begin
				push_pair(TYPE_PPPOE);
				frame_buf.push_back(PPPOE_VT);
				frame_buf.push_back(8'h00);
				push_pair(16'($urandom));
				push_pair(16'($urandom));
				if (shape == SHAPE_PPPOE_V4)
					push_pair(PPP_IPV4);
				else if (shape == SHAPE_PPPOE_V6)
					push_pair(PPP_IPV6);
				else
					push_pair(16'($urandom));
			end
		endcase
		frame_buf.push_back((shape == SHAPE_IPV6 || shape == SHAPE_PPPOE_V6) ?
			IPV6_VTC : IPV4_VIHL);
		frame_buf.push_back(8'($urandom));
		repeat (tail) frame_buf.push_back(8'($urandom));
		if (cut > 0)
			while (frame_buf.size() > cut)
				void'(frame_buf.pop_back());
	endtask

	task automatic send_frame(input logic [15:0] qlen, input bit with_first, input bit with_last);
		item_t it;
		for (int i = 0; i < frame_buf.size(); i++) begin
			it.in_byte      = frame_buf[i];
			it.first_byte   = with_first && (i == 0);
			it.last_byte    = with_last && (i == frame_buf.size() - 1);
			// The queue length only matters on the first byte.
			it.queue_length = (i == 0) ? qlen : 16'($urandom);
			send_item(it);
		end
		frames_sent++;
	endtask

	function automatic logic [15:0] pick_qlen();
		case ($urandom_range(5))
			0: return mdl_threshold;
			1: return (mdl_threshold == 16'hFFFF) ? mdl_threshold : mdl_threshold + 16'd1;
			2: return (mdl_threshold == 16'h0000) ? mdl_threshold : mdl_threshold - 16'd1;
			3: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_reset_defaults();
		// Marking is off after reset, so even a full queue leaves the frame alone.
		build_frame(SHAPE_IPV4, 0, 2, 0);
		send_frame(16'hFFFF, 1'b1, 1'b1);
	endtask

	task automatic test_directed();
		item_t it;
		set_marking(1'b1, 16'd100);
		build_frame(SHAPE_IPV4, 0, 1, 0);
		frame_buf[15] = 8'hFF;
		send_frame(16'd101, 1'b1, 1'b1);
		build_frame(SHAPE_IPV4, 0, 1, 0);
		send_frame(16'd100, 1'b1, 1'b1);
		build_frame(SHAPE_IPV6, 0, 1, 0);
		send_frame(16'hFFFF, 1'b1, 1'b1);
		build_frame(SHAPE_PPPOE_V4, 0, 0, 0);
		send_frame(16'd500, 1'b1, 1'b1);
		build_frame(SHAPE_PPPOE_V6, 0, 0, 0);
		send_frame(16'd500, 1'b1, 1'b1);
		build_frame(SHAPE_PPPOE_BAD, 0, 0, 0);
		send_frame(16'd500, 1'b1, 1'b1);
		build_frame(SHAPE_UNKNOWN, 0, 0, 0);
		send_frame(16'd500, 1'b1, 1'b1);
		build_frame(SHAPE_IPV6, MAX_TAGS, 0, 0);
		send_frame(16'd500, 1'b1, 1'b1);
		// One tag beyond the limit stops the parse.
		build_frame(SHAPE_IPV4, MAX_TAGS + 1, 0, 0);
		send_frame(16'd500, 1'b1, 1'b1);
		// Short frame ends before the TOS byte.
		build_frame(SHAPE_IPV4, 0, 0, 15);
		send_frame(16'd500, 1'b1, 1'b1);
		build_frame(SHAPE_IPV4, 0, 0, 1);
		send_frame(16'd500, 1'b1, 1'b1);
		// A frame with no start flag is never congested.
		build_frame(SHAPE_IPV4, 0, 0, 0);
		send_frame(16'd500, 1'b0, 1'b1);
		// A start flag in mid-frame begins a fresh frame.
		build_frame(SHAPE_IPV4, 0, 0, 8);
		send_frame(16'd500, 1'b1, 1'b0);
		build_frame(SHAPE_IPV4, 1, 0, 0);
		send_frame(16'd500, 1'b1, 1'b1);
		it = '{in_byte: 8'h00, first_byte: 1'b1, last_byte: 1'b0, queue_length: 16'h0000};
		send_item(it);
		it = '{in_byte: 8'hFF, first_byte: 1'b0, last_byte: 1'b1, queue_length: 16'hFFFF};
		send_item(it);
		set_marking(1'b1, 16'd0);
		build_frame(SHAPE_IPV4, 0, 0, 0);
		send_frame(16'd0, 1'b1, 1'b1);
		build_frame(SHAPE_PPPOE_V6, 0, 0, 0);
		send_frame(16'd1, 1'b1, 1'b1);
		set_marking(1'b1, 16'hFFFE);
		build_frame(SHAPE_IPV6, 0, 0, 0);
		send_frame(16'hFFFF, 1'b1, 1'b1);
	endtask

	task automatic test_backpressure();
		set_marking(1'b1, 16'd1000);
		hold_req = 80;
		build_frame(SHAPE_IPV4, 2, 50, 0);
		send_frame(16'd2000, 1'b1, 1'b1);
		build_frame(SHAPE_PPPOE_V4, 0, 10, 0);
		send_frame(16'd2000, 1'b1, 1'b1);
		// Sender waits for the output to empty before going on.
		wait_drained();
	endtask

	task automatic random_frame();
		int pick;
		int ntags;
		shape_e shape;
		item_t it;
		pick  = $urandom_range(99);
		ntags = ($urandom_range(9) == 0) ? MAX_TAGS + 1 : $urandom_range(2);
		shape = shape_e'($urandom_range(SHAPE_PPPOE_V6));
		if (pick < 75) begin
			build_frame(shape, ntags, $urandom_range(16), 0);
			send_frame(pick_qlen(), 1'b1, 1'b1);
		end else if (pick < 85) begin
			build_frame(shape, ntags, 4, $urandom_range(1, 24));
			send_frame(pick_qlen(), 1'b1, 1'b1);
		end else if (pick < 90) begin
			build_frame($urandom_range(1) ? SHAPE_UNKNOWN : SHAPE_PPPOE_BAD,
				ntags, $urandom_range(8), 0);
			send_frame(pick_qlen(), 1'b1, 1'b1);
		end else if (pick < 95) begin
			build_frame(shape, ntags, $urandom_range(8), 0);
			if ($urandom_range(1)) begin
				send_frame(pick_qlen(), 1'b0, 1'b1);
			end else begin
				send_frame(pick_qlen(), 1'b1, 1'b0);
				build_frame(shape, 0, 2, 0);
				send_frame(pick_qlen(), 1'b1, 1'b1);
			end
		end else begin
			repeat ($urandom_range(1, 12)) begin
				it.in_byte      = 8'($urandom);
				it.first_byte   = ($urandom_range(7) == 0);
				it.last_byte    = ($urandom_range(7) == 0);
				it.queue_length = 16'($urandom);
				send_item(it);
			end
		end
	endtask

	task automatic test_random();
		int goal;
		logic [15:0] thr;
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: thr = 16'h0000;
				1: thr = 16'hFFFF;
				2: thr = 16'h8000;
				default: thr = 16'($urandom);
			endcase
			set_marking(p != 4, thr);
			steady = (p == 3);
			goal = bytes_sent + 120;
			while (bytes_sent < goal)
				random_frame();
			steady = 1'b0;
		end
	endtask

	initial begin
		mdl_mark_en   = 1'b0;
		mdl_threshold = 16'hFFFF;
		clear_frame();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_directed();
		test_backpressure();
		test_random();
		wait_drained();
		repeat (20) @(posedge clk);
		$display("Covered %0d bytes in %0d frames under %0d marking settings;",
			bytes_sent, frames_sent, settings_used);
		$display("%0d bytes came out with CE marked.", bytes_marked);
		if (errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("%0d failures", errors);
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
